[rtl/core/abcse_pkg.sv]
`default_nettype none

package abcse_pkg;

   localparam int SampleBits = 16;

   localparam int MulAWidth = 33;
   localparam int MulBWidth = 18;
   localparam int MulPWidth = MulAWidth + MulBWidth;

   localparam logic [15:0] PHalf       = 16'h8000;
   localparam logic [15:0] ProbMax     = 16'hFFFE;
   localparam logic [15:0] ProbMin     = 16'h0001;
   localparam logic [31:0] RangeFull   = 32'hFFFFFFFF;
   localparam logic [31:0] RangeFloor  = 32'd3;
   localparam logic [7:0]  ByteFill    = 8'hFF;
   localparam logic [2:0]  MaxShifts   = 3'd4;
   localparam logic [3:0]  RestartBytes = 4'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_PROB,
      ST_MUL3,
      ST_ADJ,
      ST_UPDATE,
      ST_RENORM,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

[rtl/core/abcse_mul.sv]
`default_nettype none

module abcse_mul (
   input  logic                                     clock,
   input  logic                                     enable,
   input  logic signed [abcse_pkg::MulAWidth-1:0]   operand_a,
   input  logic signed [abcse_pkg::MulBWidth-1:0]   operand_b,
   output logic signed [abcse_pkg::MulPWidth-1:0]   product
);

   logic signed [abcse_pkg::MulPWidth-1:0] prod_ff;
   logic signed [abcse_pkg::MulPWidth-1:0] prod_in;

   assign prod_in = operand_a * operand_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

[rtl/core/adaptive_binary_coder_size_estimator_top.sv]
`default_nettype none

// Estimates the coded size of one bit plane under an adaptive binary arithmetic coder.
// Each transaction carries one sample; the bit chosen by the bit_plane register is coded
// and one result comes back with the bytes produced, the prediction hit flag and the
// running byte and hit totals. The block takes one sample at a time: after acceptance the
// sample makes three passes through one shared 33x18 multiplier, a range adjust and
// update, then one renormalization byte per cycle, up to four, before the result is
// presented, and the block accepts the next sample in the cycle after the result is
// registered. The result is held in an output register, so a stalled result does not
// block the next sample from being accepted. Marking a sample as the last of its plane
// flushes the coder and restores its probability state; only the totals survive. Write
// bit_plane only while the block is idle.
module adaptive_binary_coder_size_estimator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sample,
   input  logic        req_last_in_plane,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_bytes_emitted,
   output logic        rsp_prediction_hit,
   output logic [31:0] rsp_total_bytes,
   output logic [31:0] rsp_total_hits,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data
);

   abcse_pkg::state_type state_ff, state_in;

   logic [3:0]  bit_plane_ff;
   logic [15:0] zhist_ff, zhist_in;
   logic [15:0] hhist_ff, hhist_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] range_ff, range_in;
   logic [31:0] byte_total_ff, byte_total_in;
   logic [31:0] hit_total_ff, hit_total_in;
   logic        bit_ff, bit_in;
   logic        last_ff, last_in;
   logic [15:0] p0_ff, p0_in;
   logic [31:0] r2_ff, r2_in;
   logic        hit_ff, hit_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_emitted_ff, rsp_emitted_in;
   logic        rsp_hit_ff, rsp_hit_in;

   logic                                     req_accept;
   logic                                     out_free;
   logic                                     mul_enable;
   logic signed [abcse_pkg::MulAWidth-1:0]   mul_a;
   logic signed [abcse_pkg::MulBWidth-1:0]   mul_b;
   logic signed [abcse_pkg::MulPWidth-1:0]   mul_p;

   logic [16:0] zdiff;
   logic [16:0] scaled;
   logic [18:0] p0_wide;
   logic [15:0] p0_clamped;
   logic [31:0] r2_raw;
   logic [31:0] renorm_sum;
   logic [31:0] renorm_diff;
   logic        renorm_stop;
   logic        underflow;
   logic        hit_now;
   logic [3:0]  emitted;

   assign req_stall  = (state_ff != abcse_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign zdiff  = {1'b0, zhist_ff} - {1'b0, abcse_pkg::PHalf};
   assign scaled = mul_p[32:16];
   assign p0_wide = {{2{scaled[16]}}, scaled} + {3'b000, abcse_pkg::PHalf};

   always_comb begin
      if (p0_wide[18] || (p0_wide == 19'd0)) begin
         p0_clamped = abcse_pkg::ProbMin;
      end else if (p0_wide > {3'b000, abcse_pkg::ProbMax}) begin
         p0_clamped = abcse_pkg::ProbMax;
      end else begin
         p0_clamped = p0_wide[15:0];
      end
   end

   assign r2_raw      = mul_p[47:16];
   assign renorm_sum  = low_ff + range_ff;
   assign renorm_diff = low_ff ^ renorm_sum;
   assign renorm_stop = (cnt_ff == abcse_pkg::MaxShifts) || (|renorm_diff[31:24]);
   assign underflow   = (range_ff < abcse_pkg::RangeFloor);
   assign hit_now     = bit_ff ^ p0_ff[15];
   assign emitted     = {1'b0, cnt_ff}
                      + (underflow ? abcse_pkg::RestartBytes : 4'd0)
                      + (last_ff ? abcse_pkg::RestartBytes : 4'd0);

   abcse_mul u_mul (
      .clock     (clock),
      .enable    (mul_enable),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (mul_p)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         abcse_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = abcse_pkg::ST_MUL1;
            end
         end
         abcse_pkg::ST_MUL1:   state_in = abcse_pkg::ST_MUL2;
         abcse_pkg::ST_MUL2:   state_in = abcse_pkg::ST_PROB;
         abcse_pkg::ST_PROB:   state_in = abcse_pkg::ST_MUL3;
         abcse_pkg::ST_MUL3:   state_in = abcse_pkg::ST_ADJ;
         abcse_pkg::ST_ADJ:    state_in = abcse_pkg::ST_UPDATE;
         abcse_pkg::ST_UPDATE: state_in = abcse_pkg::ST_RENORM;
         abcse_pkg::ST_RENORM: begin
            if (renorm_stop) begin
               state_in = abcse_pkg::ST_FINISH;
            end
         end
         abcse_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = abcse_pkg::ST_IDLE;
            end
         end
         default: state_in = abcse_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mul_enable     = 1'b0;
      mul_a          = '0;
      mul_b          = '0;
      zhist_in       = zhist_ff;
      hhist_in       = hhist_ff;
      low_in         = low_ff;
      range_in       = range_ff;
      byte_total_in  = byte_total_ff;
      hit_total_in   = hit_total_ff;
      bit_in         = bit_ff;
      last_in        = last_ff;
      p0_in          = p0_ff;
      r2_in          = r2_ff;
      hit_in         = hit_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_emitted_in = rsp_emitted_ff;
      rsp_hit_in     = rsp_hit_ff;
      case (state_ff)
         abcse_pkg::ST_IDLE: begin
            if (req_accept) begin
               bit_in  = (32'(bit_plane_ff) < abcse_pkg::SampleBits)
                       ? req_sample[bit_plane_ff] : 1'b0;
               last_in = req_last_in_plane;
            end
         end
         abcse_pkg::ST_MUL1: begin
            mul_enable = 1'b1;
            mul_a      = {{16{zdiff[16]}}, zdiff};
            mul_b      = {2'b00, hhist_ff};
         end
         abcse_pkg::ST_MUL2: begin
            mul_enable = 1'b1;
            mul_a      = {{16{scaled[16]}}, scaled};
            mul_b      = {scaled[16], scaled};
         end
         abcse_pkg::ST_PROB: begin
            p0_in = p0_clamped;
         end
         abcse_pkg::ST_MUL3: begin
            mul_enable = 1'b1;
            mul_a      = {1'b0, range_ff};
            mul_b      = {2'b00, p0_ff};
         end
         abcse_pkg::ST_ADJ: begin
            if (r2_raw == 32'd0) begin
               r2_in = 32'd1;
            end else if (r2_raw == range_ff) begin
               r2_in = range_ff - 32'd1;
            end else begin
               r2_in = r2_raw;
            end
         end
         abcse_pkg::ST_UPDATE: begin
            if (bit_ff) begin
               low_in   = low_ff + r2_ff + 32'd1;
               range_in = range_ff + ~r2_ff;
            end else begin
               range_in = r2_ff - 32'd1;
            end
            hit_in   = hit_now;
            zhist_in = {~bit_ff, zhist_ff[15:1]};
            hhist_in = {hit_now, hhist_ff[15:1]};
            cnt_in   = 3'd0;
         end
         abcse_pkg::ST_RENORM: begin
            if (!renorm_stop) begin
               cnt_in   = cnt_ff + 3'd1;
               low_in   = {low_ff[23:0], 8'h00};
               range_in = {range_ff[23:0], abcse_pkg::ByteFill};
            end
         end
         abcse_pkg::ST_FINISH: begin
            if (out_free) begin
               if (underflow) begin
                  low_in   = 32'd0;
                  range_in = abcse_pkg::RangeFull;
               end
               if (last_ff) begin
                  low_in   = 32'd0;
                  range_in = abcse_pkg::RangeFull;
                  zhist_in = abcse_pkg::PHalf;
                  hhist_in = abcse_pkg::PHalf;
               end
               byte_total_in  = byte_total_ff + {28'd0, emitted};
               hit_total_in   = hit_total_ff + {31'd0, hit_ff};
               rsp_valid_in   = 1'b1;
               rsp_emitted_in = emitted;
               rsp_hit_in     = hit_ff;
            end
         end
         default: begin
            mul_enable = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= abcse_pkg::ST_IDLE;
         bit_plane_ff  <= 4'd0;
         zhist_ff      <= abcse_pkg::PHalf;
         hhist_ff      <= abcse_pkg::PHalf;
         low_ff        <= 32'd0;
         range_ff      <= abcse_pkg::RangeFull;
         byte_total_ff <= 32'd0;
         hit_total_ff  <= 32'd0;
         cnt_ff        <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_write_enable) begin
            bit_plane_ff <= csr_write_data;
         end
         zhist_ff      <= zhist_in;
         hhist_ff      <= hhist_in;
         low_ff        <= low_in;
         range_ff      <= range_in;
         byte_total_ff <= byte_total_in;
         hit_total_ff  <= hit_total_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff         <= bit_in;
      last_ff        <= last_in;
      p0_ff          <= p0_in;
      r2_ff          <= r2_in;
      hit_ff         <= hit_in;
      rsp_emitted_ff <= rsp_emitted_in;
      rsp_hit_ff     <= rsp_hit_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bytes_emitted  = rsp_emitted_ff;
   assign rsp_prediction_hit = rsp_hit_ff;
   assign rsp_total_bytes    = byte_total_ff;
   assign rsp_total_hits     = hit_total_ff;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == abcse_pkg::ST_FINISH))
      else $error("Result appeared without a finished transaction.");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= abcse_pkg::MaxShifts)
      else $error("Renormalization exceeded four shifts.");

   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abcse_pkg::ST_MUL3) |-> (p0_ff != 16'd0 && p0_ff != 16'hFFFF))
      else $error("Zero probability outside its clamp range.");

   a_emitted_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_emitted_ff <= 4'd12))
      else $error("Byte count of a result exceeds twelve.");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (hit_total_ff == $past(hit_total_ff) + {31'd0, rsp_hit_ff}))
      else $error("Hit total did not follow the reported hit.");
`endif

endmodule

`default_nettype wire

[tb/tb_adaptive_binary_coder_size_estimator_top.sv]
module tb_adaptive_binary_coder_size_estimator_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomItems = 1600;
   localparam int HoldCycles  = 300;

   typedef struct packed {
      logic [3:0]  bytes_emitted;
      logic        prediction_hit;
      logic [31:0] total_bytes;
      logic [31:0] total_hits;
   } coded_result_type;

   typedef struct packed {
      logic [3:0]       plane;
      logic [15:0]      smp;
      logic             lst;
      logic             typed;
      coded_result_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_sample;
   logic        req_last_in_plane;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_bytes_emitted;
   logic        rsp_prediction_hit;
   logic [31:0] rsp_total_bytes;
   logic [31:0] rsp_total_hits;
   logic        csr_write_enable;
   logic [3:0]  csr_write_data;

   logic [3:0]  plane_sel;
   logic [15:0] zero_hist;
   logic [15:0] hit_hist;
   logic [31:0] code_low;
   logic [31:0] code_range;
   logic [31:0] byte_sum;
   logic [31:0] hit_sum;

   coded_result_type expected_results[$];
   int  mismatch_count = 0;
   int  sent_count = 0;
   bit  quiet = 1'b0;
   bit  hold_req = 1'b0;

   directed_row_type directed_rows [22] = '{
      '{4'd0,  16'h0000, 1'b1, 1'b1, '{4'd4, 1'b1, 32'd4,  32'd1}},
      '{4'd0,  16'h0001, 1'b1, 1'b1, '{4'd4, 1'b0, 32'd8,  32'd1}},
      '{4'd0,  16'hFFFF, 1'b1, 1'b1, '{4'd4, 1'b0, 32'd12, 32'd1}},
      '{4'd0,  16'hFFFE, 1'b0, 1'b0, '0},
      '{4'd0,  16'hFFFE, 1'b0, 1'b0, '0},
      '{4'd0,  16'h0000, 1'b0, 1'b0, '0},
      '{4'd0,  16'hAAAA, 1'b0, 1'b0, '0},
      '{4'd0,  16'h5554, 1'b0, 1'b0, '0},
      '{4'd0,  16'h0000, 1'b0, 1'b0, '0},
      '{4'd15, 16'h8000, 1'b0, 1'b0, '0},
      '{4'd15, 16'h7FFF, 1'b0, 1'b0, '0},
      '{4'd15, 16'hFFFF, 1'b0, 1'b0, '0},
      '{4'd15, 16'h8001, 1'b0, 1'b0, '0},
      '{4'd15, 16'h0000, 1'b1, 1'b0, '0},
      '{4'd7,  16'h0080, 1'b0, 1'b0, '0},
      '{4'd7,  16'hFF7F, 1'b0, 1'b0, '0},
      '{4'd7,  16'h0080, 1'b0, 1'b0, '0},
      '{4'd7,  16'hFF7F, 1'b0, 1'b0, '0},
      '{4'd7,  16'hFFFF, 1'b0, 1'b0, '0},
      '{4'd7,  16'hFFFF, 1'b1, 1'b0, '0},
      '{4'd3,  16'h0008, 1'b1, 1'b0, '0},
      '{4'd3,  16'hFFF7, 1'b1, 1'b0, '0}
   };

   adaptive_binary_coder_size_estimator_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_last_in_plane  (req_last_in_plane),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bytes_emitted  (rsp_bytes_emitted),
      .rsp_prediction_hit (rsp_prediction_hit),
      .rsp_total_bytes    (rsp_total_bytes),
      .rsp_total_hits     (rsp_total_hits),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_coder();
      zero_hist  = abcse_pkg::PHalf;
      hit_hist   = abcse_pkg::PHalf;
      code_low   = '0;
      code_range = abcse_pkg::RangeFull;
   endfunction

   function automatic coded_result_type code_sample(input logic [15:0] smp,
                                                    input logic lst);
      coded_result_type r;
      logic          bitv;
      logic          guess_hit;
      longint        dz;
      longint        scaled;
      longint        prob;
      logic [63:0]   prod;
      logic [31:0]   split;
      logic [3:0]    nbytes;
      int            shifts;
      bitv = smp[plane_sel];
      dz = zero_hist;
      dz = dz - 32768;
      scaled = hit_hist;
      scaled = (dz * scaled) >>> 16;
      prob = ((scaled * scaled) >>> 16) + 32768;
      if (prob < 1) prob = 1;
      if (prob > 65534) prob = 65534;
      prod = code_range * prob[15:0];
      split = prod[47:16];
      if (split == 0) split = 1;
      else if (split == code_range) split = split - 1;
      if (bitv) begin
         split = split + 1;
         code_low = code_low + split;
         code_range = code_range - split;
      end else begin
         code_range = split - 1;
      end
      guess_hit = bitv ^ (prob >= 32768);
      zero_hist = {~bitv, zero_hist[15:1]};
      hit_hist  = {guess_hit, hit_hist[15:1]};
      nbytes = '0;
      shifts = 0;
      while (shifts < 4 && (code_low ^ (code_low + code_range)) < 32'h0100_0000) begin
         nbytes++;
         code_low = code_low << 8;
         code_range = {code_range[23:0], abcse_pkg::ByteFill};
         shifts++;
      end
      if (code_range < abcse_pkg::RangeFloor) begin
         nbytes += abcse_pkg::RestartBytes;
         code_low = '0;
         code_range = abcse_pkg::RangeFull;
      end
      if (lst) begin
         nbytes += abcse_pkg::RestartBytes;
         restart_coder();
      end
      byte_sum += nbytes;
      hit_sum += guess_hit;
      r.bytes_emitted  = nbytes;
      r.prediction_hit = guess_hit;
      r.total_bytes    = byte_sum;
      r.total_hits     = hit_sum;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatch_count++;
      $display("%0t: %0s mismatch, got %0h expected %0h", $realtime, what, got, want);
   endtask

   task automatic offer_sample(input logic [15:0] smp, input logic lst, input logic typed,
                               input coded_result_type want);
      coded_result_type predicted;
      req_valid <= 1'b1;
      req_sample <= smp;
      req_last_in_plane <= lst;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = code_sample(smp, lst);
      expected_results.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   task automatic sender_gap();
      while (!quiet && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // The coder is idle once every transaction in flight has returned its result.
   task automatic write_plane(input logic [3:0] plane);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= plane;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      plane_sel = plane;
   endtask

   always @(posedge clock) begin
      coded_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            flag_mismatch("unexpected transaction", rsp_total_bytes, '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bytes_emitted !== want.bytes_emitted)
               flag_mismatch("bytes_emitted", rsp_bytes_emitted, want.bytes_emitted);
            if (rsp_prediction_hit !== want.prediction_hit)
               flag_mismatch("prediction_hit", rsp_prediction_hit, want.prediction_hit);
            if (rsp_total_bytes !== want.total_bytes)
               flag_mismatch("total_bytes", rsp_total_bytes, want.total_bytes);
            if (rsp_total_hits !== want.total_hits)
               flag_mismatch("total_hits", rsp_total_hits, want.total_hits);
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_req = 1'b0;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 16);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("adaptive_binary_coder_size_estimator_top regression: fail");
      $finish;
   end

   initial begin
      logic [3:0]  plane;
      logic [15:0] smp;
      logic        bitv;
      logic        lst;
      int          len;
      int          bit_style;
      int          guard;
      bit          hold_done;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_last_in_plane = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      plane_sel = '0;
      byte_sum = '0;
      hit_sum = '0;
      hold_done = 1'b0;
      restart_coder();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].plane != plane_sel) write_plane(directed_rows[i].plane);
         offer_sample(directed_rows[i].smp, directed_rows[i].lst, directed_rows[i].typed,
                      directed_rows[i].want);
         sender_gap();
      end

      // Mostly complete plane passes with skewed bit statistics; some passes end
      // without a flush so that the next plane starts on a live coder.
      while (sent_count < RandomItems + $size(directed_rows)) begin
         case ($urandom_range(9))
            0: plane = 4'd0;
            1: plane = 4'd15;
            default: plane = 4'($urandom_range(15));
         endcase
         write_plane(plane);
         len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
         bit_style = $urandom_range(4);
         bitv = 1'($urandom_range(1));
         for (int i = 0; i < len; i++) begin
            quiet = (sent_count >= 500 && sent_count < 800);
            if (!hold_done && sent_count >= 1000) begin
               hold_req = 1'b1;
               hold_done = 1'b1;
            end
            smp = 16'($urandom);
            case (bit_style)
               0: bitv = smp[plane];
               1: bitv = ($urandom_range(9) == 0);
               2: bitv = ($urandom_range(9) != 0);
               3: bitv = ~bitv;
               default: if ($urandom_range(19) == 0) bitv = ~bitv;
            endcase
            smp[plane] = bitv;
            if (i == len - 1) lst = ($urandom_range(9) != 0);
            else lst = ($urandom_range(49) == 0);
            offer_sample(smp, lst, 1'b0, '0);
            sender_gap();
         end
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      guard = 0;
      while (expected_results.size() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0)
         flag_mismatch("missing transaction", 32'(expected_results.size()), '0);
      if (mismatch_count == 0) begin
         $display("adaptive_binary_coder_size_estimator_top regression: pass");
      end else begin
         $display("adaptive_binary_coder_size_estimator_top regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/abcse_pkg.sv
rtl/core/abcse_mul.sv
rtl/core/adaptive_binary_coder_size_estimator_top.sv
tb/tb_adaptive_binary_coder_size_estimator_top.sv
